/* rtl/anfpa_pkg.sv */
// ============================================================================
// anfpa_pkg - shared types and constants of the aligned next-fit allocator
// Field widths, controller states and the command/status bundles that join
// the controller to the datapath.
// ============================================================================
package anfpa_pkg;

    // Field widths of the request, response and configuration register
    localparam int SIZE_W    = 26;
    localparam int ALIGN_W   = 4;
    localparam int START_W   = 13;
    localparam int CFG_W     = 14;
    localparam int CFG_RESET = 8192;

    // Controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CAND,
        ST_SCAN,
        ST_MARK,
        ST_FIN
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clr_step;
        logic load_req;
        logic start_pass2;
        logic cand;
        logic scan_adv;
        logic scan_skip;
        logic mark_init;
        logic mark_step;
        logic set_last;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clr_last;
        logic n_zero;
        logic cand_fits;
        logic left_zero;
        logic t_ge_e;
        logic pg_taken;
        logic out_busy;
    } t_sts;

endpackage

/* rtl/anfpa_req_if.sv */
// ============================================================================
// anfpa_req_if - allocation request channel
// Valid/ready channel carrying the byte size and page alignment.
// ============================================================================
interface anfpa_req_if;
    import anfpa_pkg::*;

    logic               valid;
    logic               ready;
    logic [SIZE_W-1:0]  size_bytes;
    logic [ALIGN_W-1:0] align_log2;

    modport source (output valid, output size_bytes, output align_log2, input ready);
    modport sink   (input valid, input size_bytes, input align_log2, output ready);
endinterface

/* rtl/anfpa_rsp_if.sv */
// ============================================================================
// anfpa_rsp_if - allocation response channel
// Valid/ready channel carrying the found flag and the start page.
// ============================================================================
interface anfpa_rsp_if;
    import anfpa_pkg::*;

    logic               valid;
    logic               ready;
    logic               found;
    logic [START_W-1:0] first_page;

    modport source (output valid, output found, output first_page, input ready);
    modport sink   (input valid, input found, input first_page, output ready);
endinterface

/* rtl/anfpa_ctrl.sv */
// ============================================================================
// anfpa_ctrl - allocator sequencer
// Steps through map clearing, candidate setup, page scanning, marking and
// response hand-off by issuing commands to the datapath.
// ============================================================================
module anfpa_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  anfpa_pkg::t_sts i_sts,
    output anfpa_pkg::t_cmd o_cmd
);
    import anfpa_pkg::*;

    t_state r_state, n_state;
    logic   r_pass2, n_pass2;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_pass2 <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pass2 <= n_pass2;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_pass2     = r_pass2;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_pass2        = 1'b0;
                    n_state        = ST_CAND;
                end
            end
            ST_CAND: begin
                priority if (i_sts.n_zero) begin
                    n_state = ST_FIN;
                end else if (i_sts.cand_fits) begin
                    o_cmd.cand = 1'b1;
                    n_state    = ST_SCAN;
                end else if (!r_pass2) begin
                    o_cmd.start_pass2 = 1'b1;
                    n_pass2           = 1'b1;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_SCAN: begin
                priority if (i_sts.left_zero) begin
                    o_cmd.mark_init = 1'b1;
                    n_state         = ST_MARK;
                end else if (i_sts.t_ge_e) begin
                    // give up this pass
                    if (!r_pass2) begin
                        o_cmd.start_pass2 = 1'b1;
                        n_pass2           = 1'b1;
                        n_state           = ST_CAND;
                    end else begin
                        n_state = ST_FIN;
                    end
                end else if (i_sts.pg_taken) begin
                    o_cmd.scan_skip = 1'b1;
                    n_state         = ST_CAND;
                end else begin
                    o_cmd.scan_adv = 1'b1;
                end
            end
            ST_MARK: begin
                if (i_sts.left_zero) begin
                    o_cmd.set_last = 1'b1;
                    n_state        = ST_FIN;
                end else begin
                    o_cmd.mark_step = 1'b1;
                end
            end
            ST_FIN: begin
                if (!i_sts.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

endmodule

/* rtl/anfpa_dp.sv */
// ============================================================================
// anfpa_dp - allocator datapath
// Holds the page used map, the search pointers, the last-allocation mark,
// the usable page register and the response register.
// ============================================================================
module anfpa_dp #(
    parameter int NUM_PAGES       = 8192,
    parameter int RESERVED_PAGES  = 4096,
    parameter int PAGE_BYTES_LOG2 = 12
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  anfpa_pkg::t_cmd                  i_cmd,
    output anfpa_pkg::t_sts                  o_sts,
    input  logic                             i_cfg_we,
    input  logic [anfpa_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic [anfpa_pkg::SIZE_W-1:0]     i_size_bytes,
    input  logic [anfpa_pkg::ALIGN_W-1:0]    i_align_log2,
    input  logic                             i_rsp_ready,
    output logic                             o_rsp_valid,
    output logic                             o_rsp_found,
    output logic [anfpa_pkg::START_W-1:0]    o_rsp_first_page
);
    import anfpa_pkg::*;

    localparam int PW       = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int NW       = SIZE_W + 1 - PAGE_BYTES_LOG2;
    localparam int WW0      = (PW > NW) ? PW : NW;
    localparam int WW       = ((WW0 > 17) ? WW0 : 17) + 2;
    localparam int R_SAT    = (RESERVED_PAGES > NUM_PAGES) ? NUM_PAGES : RESERVED_PAGES;
    localparam int LAST_RST = (R_SAT == 0) ? NUM_PAGES - 1 : R_SAT - 1;
    localparam int PG_MASK  = (1 << PAGE_BYTES_LOG2) - 1;

    // Page used map
    logic mem [NUM_PAGES];

    logic [NW-1:0]      r_n, n_n;
    logic [NW-1:0]      r_left, n_left;
    logic [WW-1:0]      r_amask, n_amask;
    logic [WW-1:0]      r_i, n_i;
    logic [WW-1:0]      r_e, n_e;
    logic [WW-1:0]      r_c, n_c;
    logic [WW-1:0]      r_t, n_t;
    logic [PW-1:0]      r_last, n_last;
    logic [PW-1:0]      r_clr;
    logic [CFG_W-1:0]   r_usable;
    logic               r_found, n_found;
    logic [START_W-1:0] r_at, n_at;
    logic               r_rd_data;
    logic               r_out_valid;
    logic               r_out_found;
    logic [START_W-1:0] r_out_start;

    logic [SIZE_W:0]    w_size_up;
    logic [NW-1:0]      w_n;
    logic [WW-1:0]      w_amask;
    logic [WW-1:0]      w_use_e;
    logic               w_wr_en;
    logic [PW-1:0]      w_wr_addr;
    logic               w_wr_data;

    // Round size up to pages, form alignment mask, saturate the usable end
    assign w_size_up = {1'b0, i_size_bytes} + (SIZE_W+1)'(PG_MASK);
    assign w_n       = NW'(w_size_up >> PAGE_BYTES_LOG2);
    assign w_amask   = (WW'(1) << i_align_log2) - WW'(1);
    assign w_use_e   = (WW'(r_usable) > WW'(NUM_PAGES)) ? WW'(NUM_PAGES) : WW'(r_usable);

    // Next values of the search registers
    always_comb begin
        n_n     = r_n;
        n_amask = r_amask;
        n_i     = r_i;
        n_e     = r_e;
        n_c     = r_c;
        n_t     = r_t;
        n_left  = r_left;
        n_last  = r_last;
        n_found = r_found;
        n_at    = r_at;
        if (i_cmd.load_req) begin
            n_n     = w_n;
            n_amask = w_amask;
            n_i     = WW'(r_last) + WW'(1);
            n_e     = w_use_e;
            n_found = 1'b0;
            n_at    = '0;
        end
        if (i_cmd.start_pass2) begin
            n_i = '0;
            n_e = WW'(r_last);
        end
        if (i_cmd.cand) begin
            n_c    = (r_i + r_amask) & ~r_amask;
            n_t    = (r_i + r_amask) & ~r_amask;
            n_left = r_n;
        end
        if (i_cmd.scan_adv || i_cmd.mark_step) begin
            n_t    = r_t + WW'(1);
            n_left = r_left - NW'(1);
        end
        if (i_cmd.scan_skip) begin
            n_i = r_t + WW'(1);
        end
        if (i_cmd.mark_init) begin
            n_t     = r_c;
            n_left  = r_n;
            n_found = 1'b1;
            n_at    = START_W'(r_c);
        end
        if (i_cmd.set_last) begin
            n_last = PW'(r_c + WW'(r_n) - WW'(1));
        end
    end

    // Search and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last      <= PW'(LAST_RST);
            r_clr       <= '0;
            r_usable    <= CFG_W'(CFG_RESET);
            r_out_valid <= 1'b0;
        end else begin
            r_last <= n_last;
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + PW'(1);
            end
            if (i_cfg_we) begin
                r_usable <= i_cfg_wdata;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_n     <= n_n;
        r_amask <= n_amask;
        r_i     <= n_i;
        r_e     <= n_e;
        r_c     <= n_c;
        r_t     <= n_t;
        r_left  <= n_left;
        r_found <= n_found;
        r_at    <= n_at;
        if (i_cmd.load_out) begin
            r_out_found <= r_found;
            r_out_start <= r_at;
        end
    end

    // Map write port: clearing pass or marking
    assign w_wr_en   = i_cmd.clr_step | i_cmd.mark_step;
    assign w_wr_addr = i_cmd.clr_step ? r_clr : r_t[PW-1:0];
    assign w_wr_data = i_cmd.clr_step ? ({1'b0, r_clr} < (PW+1)'(R_SAT)) : 1'b1;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr] <= w_wr_data;
        end
    end

    // Map read port: fetch the page the scan pointer moves to
    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[n_t[PW-1:0]];
    end

    // Status
    assign o_sts.clr_last  = (r_clr == PW'(NUM_PAGES - 1));
    assign o_sts.n_zero    = (r_n == '0);
    assign o_sts.cand_fits = ((r_i + WW'(r_n)) <= r_e);
    assign o_sts.left_zero = (r_left == '0);
    assign o_sts.t_ge_e    = (r_t >= r_e);
    assign o_sts.pg_taken  = r_rd_data;
    assign o_sts.out_busy  = r_out_valid & ~i_rsp_ready;

    assign o_rsp_valid      = r_out_valid;
    assign o_rsp_found      = r_out_found;
    assign o_rsp_first_page = r_out_start;

endmodule

/* rtl/aligned_next_fit_page_allocator_core.sv */
// ============================================================================
// aligned_next_fit_page_allocator_core - aligned next-fit page allocator
// Rounds each request to pages, searches the used map for an aligned free
// run in two next-fit passes, marks it used and returns the start page.
// ============================================================================
//
//  channel   dir  handshake       payload
//  i_req     in   valid / ready   size_bytes[25:0], align_log2[3:0]
//  o_rsp     out  valid / ready   found, first_page[12:0]
//  i_cfg     in   i_cfg_we        i_cfg_wdata[13:0] (usable_pages)
//
//  One request at a time: the request is accepted, each candidate start or
//  pass change is set up, pages are scanned one by one until the scan ends,
//  the n pages of the run are marked and the result is handed off.
//  After reset a clearing pass writes the whole map with i_req.ready low.
//  A waiting result lets one more search run; that search holds at the
//  hand-off (ST_FIN) until the response register frees.
//
module aligned_next_fit_page_allocator_core #(
    parameter int NUM_PAGES       = 8192,
    parameter int RESERVED_PAGES  = 4096,
    parameter int PAGE_BYTES_LOG2 = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [anfpa_pkg::CFG_W-1:0] i_cfg_wdata,
    anfpa_req_if.sink                   i_req,
    anfpa_rsp_if.source                 o_rsp
);
    import anfpa_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_req_ready;

    // Sequencer
    anfpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_req_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Map, pointers and response register
    anfpa_dp #(
        .NUM_PAGES       (NUM_PAGES),
        .RESERVED_PAGES  (RESERVED_PAGES),
        .PAGE_BYTES_LOG2 (PAGE_BYTES_LOG2)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_size_bytes     (i_req.size_bytes),
        .i_align_log2     (i_req.align_log2),
        .i_rsp_ready      (o_rsp.ready),
        .o_rsp_valid      (o_rsp.valid),
        .o_rsp_found      (o_rsp.found),
        .o_rsp_first_page (o_rsp.first_page)
    );

    assign i_req.ready = w_req_ready;

endmodule
